// ===== hdl/vus_pkg.sv =====
// ----------------------------------------------------------------------------
// vus_pkg: shared types and constants for the utterance segmenter
// event and action codes, register indexes and reset values, widths and internal structs
// ----------------------------------------------------------------------------
`default_nettype none

package vus_pkg;

   // counter, event code and csr field widths
   localparam int COUNT_W   = 12;
   localparam int PRE_W     = 8;
   localparam int SIL_W     = 10;
   localparam int EVENT_W   = 3;
   localparam int CSR_ADR_W = 2;
   localparam int CSR_DAT_W = 12;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SIL_W-1:0]   SIL_MAX   = {SIL_W{1'b1}};

   // event codes
   localparam logic [EVENT_W-1:0] EV_IDLE_FLUSH = 3'd0;
   localparam logic [EVENT_W-1:0] EV_PREROLL    = 3'd1;
   localparam logic [EVENT_W-1:0] EV_STARTED    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_APPENDED   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_COMPLETE   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_DISCARDED  = 3'd5;

   // action codes
   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // register indexes
   localparam logic [CSR_ADR_W-1:0] REG_PREROLL_LIMIT = 2'd0;
   localparam logic [CSR_ADR_W-1:0] REG_END_SILENCE   = 2'd1;
   localparam logic [CSR_ADR_W-1:0] REG_MIN_SPEECH    = 2'd2;
   localparam logic [CSR_ADR_W-1:0] REG_MAX_UTTERANCE = 2'd3;

   // register reset values
   localparam logic [PRE_W-1:0] PREROLL_LIMIT_RST = 8'd20;
   localparam logic [SIL_W-1:0] END_SILENCE_RST   = 10'd40;
   localparam logic [SIL_W-1:0] MIN_SPEECH_RST    = 10'd8;
   localparam logic [11:0]      MAX_UTTERANCE_RST = 12'd3000;

   typedef struct packed {
      logic [PRE_W-1:0] preroll_limit;
      logic [SIL_W-1:0] end_silence;
      logic [SIL_W-1:0] min_speech;
      logic [11:0]      max_utterance;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [COUNT_W-1:0] utterance_frames;
      logic               speaking;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/vus_utterance_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// vad_utterance_segmenter_top: frame-level speech endpointing
// pre-roll, start, append, hangover or max-length end and flush over per-frame vad verdicts
// ----------------------------------------------------------------------------
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+-----------------------------------
//  req_*     | in  | req_tvalid / req_tready | tuser: action; tdata: frame_is_speech
//  rsp_*     | out | rsp_tvalid / rsp_tready | tuser: event_res;
//            |     |                         | tdata: utterance_frames, speaking
//  csr_*     | in  | csr_we                  | csr_addr register index, csr_wdata
//
//  one request per cycle while req_tready is high; its result shows on rsp in the cycle after acceptance
//  the state update and the result are computed in the accept cycle and the
//  result sits in a single output register
//  req_tready is low only while that register holds a result that is not taken
//  synchronous active-high reset clears the counters and the output valid and
//  returns the registers to 20 / 40 / 8 / 3000
// ----------------------------------------------------------------------------
`default_nettype none

module vad_utterance_segmenter_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [0] frame_is_speech, [7:1] zero
   input  wire logic         req_tuser,   // [0] action
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [11:0] utterance_frames, [12] speaking, [15:13] zero
   output logic [2:0]        rsp_tuser,   // [2:0] event_res
   // configuration write port
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [11:0]  csr_wdata
);

   vus_pkg::cfg_type    cfg;
   vus_pkg::result_type result;
   vus_pkg::result_type rsp_data;
   logic                room;
   logic                req_accept;

   assign req_tready = room;
   assign req_accept = req_tvalid && room;

   vus_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // counters move only on an accepted request
   vus_seg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .action    (req_tuser),
      .is_speech (req_tdata[0]),
      .cfg       (cfg),
      .result    (result)
   );

   vus_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data),
      .room       (room)
   );

   assign rsp_tuser = rsp_data.event_res;
   assign rsp_tdata = {3'b000, rsp_data.speaking, rsp_data.utterance_frames};

   // a stalled result blocks new requests
   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

   // an ended utterance reports not speaking
   a_end_not_speaking : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == vus_pkg::EV_COMPLETE ||
                      rsp_tuser == vus_pkg::EV_DISCARDED)) |-> !rsp_tdata[12])
      else $error("speaking set on ended utterance");

   // start and append report speaking
   a_open_speaking : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == vus_pkg::EV_STARTED ||
                      rsp_tuser == vus_pkg::EV_APPENDED)) |-> rsp_tdata[12])
      else $error("speaking clear inside utterance");

   // idle events carry no length
   a_idle_zero_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == vus_pkg::EV_PREROLL ||
                      rsp_tuser == vus_pkg::EV_IDLE_FLUSH)) |-> (rsp_tdata[12:0] == 13'd0))
      else $error("idle event with length or speaking");

   // an accepted request always yields a valid result next cycle
   a_accept_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted request lost");

endmodule

`default_nettype wire

// ===== hdl/vus_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vus_cfg_regs: configuration register file
// write-only registers loaded from the csr write port
// ----------------------------------------------------------------------------
`default_nettype none

module vus_cfg_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [vus_pkg::CSR_ADR_W-1:0]   csr_addr,
   input  wire logic [vus_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output vus_pkg::cfg_type                     cfg
);

   vus_pkg::cfg_type cfg_ff;
   vus_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            vus_pkg::REG_PREROLL_LIMIT:
               cfg_in.preroll_limit = csr_wdata[vus_pkg::PRE_W-1:0];
            vus_pkg::REG_END_SILENCE:
               cfg_in.end_silence = csr_wdata[vus_pkg::SIL_W-1:0];
            vus_pkg::REG_MIN_SPEECH:
               cfg_in.min_speech = csr_wdata[vus_pkg::SIL_W-1:0];
            vus_pkg::REG_MAX_UTTERANCE:
               cfg_in.max_utterance = csr_wdata[11:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preroll_limit <= vus_pkg::PREROLL_LIMIT_RST;
         cfg_ff.end_silence   <= vus_pkg::END_SILENCE_RST;
         cfg_ff.min_speech    <= vus_pkg::MIN_SPEECH_RST;
         cfg_ff.max_utterance <= vus_pkg::MAX_UTTERANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/vus_seg_core.sv =====
// ----------------------------------------------------------------------------
// vus_seg_core: endpointing state and per-frame update
// holds the segmenter counters and computes the result of one request
// ----------------------------------------------------------------------------
`default_nettype none

module vus_seg_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                action,
   input  wire logic                is_speech,
   input  wire vus_pkg::cfg_type    cfg,
   output vus_pkg::result_type      result
);

   logic                        in_utt_ff,  in_utt_in;
   logic [vus_pkg::PRE_W-1:0]   pre_ff,     pre_in;
   logic [vus_pkg::COUNT_W-1:0] utt_ff,     utt_in;
   logic [vus_pkg::COUNT_W-1:0] spc_ff,     spc_in;
   logic [vus_pkg::SIL_W-1:0]   sil_ff,     sil_in;

   logic [vus_pkg::PRE_W-1:0]   pre_next;
   logic [vus_pkg::COUNT_W-1:0] utt_next;
   logic [vus_pkg::COUNT_W-1:0] spc_next;
   logic [vus_pkg::SIL_W-1:0]   sil_next;
   logic [vus_pkg::COUNT_W-1:0] min_speech_ext;
   logic                        keep_flush;
   logic                        keep_end;
   logic                        end_hit;

   always_comb begin
      min_speech_ext = vus_pkg::COUNT_W'(cfg.min_speech);

      // pre-roll count clamps to the limit
      pre_next = (pre_ff < cfg.preroll_limit) ? pre_ff + 1'b1 : cfg.preroll_limit;

      // saturating counters while speaking
      utt_next = (utt_ff != vus_pkg::COUNT_MAX) ? utt_ff + 1'b1 : utt_ff;
      if (is_speech) begin
         spc_next = (spc_ff != vus_pkg::COUNT_MAX) ? spc_ff + 1'b1 : spc_ff;
         sil_next = '0;
      end else begin
         spc_next = spc_ff;
         sil_next = (sil_ff != vus_pkg::SIL_MAX) ? sil_ff + 1'b1 : sil_ff;
      end

      end_hit = (sil_next >= cfg.end_silence) ||
                (utt_next >= vus_pkg::COUNT_W'(cfg.max_utterance));
      keep_flush = (spc_ff >= min_speech_ext) && (utt_ff != '0);
      keep_end   = (spc_next >= min_speech_ext) && (utt_next != '0);

      in_utt_in = in_utt_ff;
      pre_in    = pre_ff;
      utt_in    = utt_ff;
      spc_in    = spc_ff;
      sil_in    = sil_ff;

      result.event_res        = vus_pkg::EV_IDLE_FLUSH;
      result.utterance_frames = '0;

      if (action == vus_pkg::ACT_FLUSH) begin
         if (in_utt_ff) begin
            result.utterance_frames = utt_ff;
            result.event_res = keep_flush ? vus_pkg::EV_COMPLETE : vus_pkg::EV_DISCARDED;
         end
         in_utt_in = 1'b0;
         pre_in    = '0;
         utt_in    = '0;
         spc_in    = '0;
         sil_in    = '0;
      end else if (!in_utt_ff) begin
         if (is_speech) begin
            // open an utterance that includes the pre-roll
            in_utt_in = 1'b1;
            pre_in    = '0;
            utt_in    = vus_pkg::COUNT_W'(pre_next);
            spc_in    = vus_pkg::COUNT_W'(1);
            sil_in    = '0;
            result.utterance_frames = vus_pkg::COUNT_W'(pre_next);
            result.event_res        = vus_pkg::EV_STARTED;
         end else begin
            pre_in           = pre_next;
            result.event_res = vus_pkg::EV_PREROLL;
         end
      end else begin
         result.utterance_frames = utt_next;
         if (end_hit) begin
            result.event_res = keep_end ? vus_pkg::EV_COMPLETE : vus_pkg::EV_DISCARDED;
            in_utt_in = 1'b0;
            pre_in    = '0;
            utt_in    = '0;
            spc_in    = '0;
            sil_in    = '0;
         end else begin
            result.event_res = vus_pkg::EV_APPENDED;
            utt_in = utt_next;
            spc_in = spc_next;
            sil_in = sil_next;
         end
      end

      result.speaking = in_utt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_utt_ff <= 1'b0;
         pre_ff    <= '0;
         utt_ff    <= '0;
         spc_ff    <= '0;
         sil_ff    <= '0;
      end else if (load) begin
         in_utt_ff <= in_utt_in;
         pre_ff    <= pre_in;
         utt_ff    <= utt_in;
         spc_ff    <= spc_in;
         sil_ff    <= sil_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vus_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// vus_rsp_reg: response output register
// holds one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module vus_rsp_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire vus_pkg::result_type  result,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output vus_pkg::result_type       rsp_data,
   output logic                      room
);

   logic                valid_ff, valid_in;
   vus_pkg::result_type data_ff;

   // a new result may land when the slot is empty or drains this cycle
   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

`default_nettype wire
